// File: rtl/core/acfd_pkg.sv
package acfd_pkg;

  // Default frame limits.
  localparam int BUFFER_LEN_DEF   = 40;
  localparam int NUMBER_CHARS_DEF = 6;

  // Depth of the job queue between the front and back parts.
  localparam int JOBQ_DEPTH = 4;

  // Value arithmetic.
  localparam int          VALUE_W     = 38;
  localparam int          FR_W        = 17;
  localparam logic [2:0]  FRAC_DIGITS = 3'd5;
  localparam logic [16:0] SCALE       = 17'd100000;
  localparam logic [63:0] POS_LIMIT   = 64'd137438953471;
  localparam logic [63:0] NEG_LIMIT   = 64'd137438953472;

  // Frame bytes.
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Command codes.
  localparam logic [2:0] CMD_STOP = 3'd0;
  localparam logic [2:0] CMD_W_P  = 3'd1;
  localparam logic [2:0] CMD_W_I  = 3'd3;
  localparam logic [2:0] CMD_W_D  = 3'd5;
  localparam logic [2:0] CMD_WAVE = 3'd7;

  // Frame status codes.
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_DISCARD = 1'b1;

  // Classification of an ended frame, handed from front to back.
  typedef struct packed {
    logic       status;
    logic [2:0] code;
    logic       zero;
    logic       allow_point;
  } job_ctl_t;

endpackage

// File: rtl/core/acfd_front.sv
module acfd_front #(
  parameter int BUFFER_LEN   = acfd_pkg::BUFFER_LEN_DEF,
  parameter int NUMBER_CHARS = acfd_pkg::NUMBER_CHARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        byte_acc,
  input  logic [7:0]                  rx_byte,
  output logic                        job_push,
  output acfd_pkg::job_ctl_t          job_ctl,
  output logic [$clog2(NUMBER_CHARS+1)-1:0] job_len,
  output logic [NUMBER_CHARS*8-1:0]   job_text
);

  localparam int CNT_W = $clog2(BUFFER_LEN + 1);
  localparam int LEN_W = $clog2(NUMBER_CHARS + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       head_r, head_nxt;
  logic             nul_r, nul_nxt;
  logic [7:0]       text_r   [NUMBER_CHARS];
  logic [7:0]       text_nxt [NUMBER_CHARS];

  logic [CNT_W-1:0] cnt1;
  logic [CNT_W-1:0] len_full;
  logic             first;
  logic             is_hash;
  logic             is_tail;
  logic             at_full;
  logic             ends;
  logic             nul_eff;
  logic [7:0]       head_eff;
  logic [2:0]       tail_base;

  // Position bookkeeping for the incoming byte.
  always_comb begin
    first    = (cnt_r == '0);
    cnt1     = cnt_r + CNT_W'(1);
    at_full  = (cnt1 >= CNT_W'(BUFFER_LEN));
    is_hash  = (rx_byte == acfd_pkg::CH_HASH);
    is_tail  = (rx_byte == acfd_pkg::CH_P) || (rx_byte == acfd_pkg::CH_I) ||
               (rx_byte == acfd_pkg::CH_D);
    ends     = is_hash || is_tail || at_full;
    head_eff = first ? rx_byte : head_r;
    nul_eff  = nul_r || (!first && (rx_byte == acfd_pkg::CH_NUL));
  end

  // Number text capture; the current byte is written in place.
  always_comb begin
    text_nxt = text_r;
    for (int i = 0; i < NUMBER_CHARS; i++) begin
      if (cnt_r == CNT_W'(i + 1)) begin
        text_nxt[i] = rx_byte;
      end
    end
    for (int i = 0; i < NUMBER_CHARS; i++) begin
      job_text[i*8 +: 8] = text_nxt[i];
    end
  end

  // Number length seen by the back part.
  always_comb begin
    len_full = first ? '0 : (cnt_r - CNT_W'(1));
    if (len_full > CNT_W'(NUMBER_CHARS)) begin
      job_len = LEN_W'(NUMBER_CHARS);
    end else begin
      job_len = LEN_W'(len_full);
    end
  end

  // Frame classification into a command job.
  always_comb begin
    case (rx_byte)
      acfd_pkg::CH_P: tail_base = acfd_pkg::CMD_W_P;
      acfd_pkg::CH_I: tail_base = acfd_pkg::CMD_W_I;
      default:        tail_base = acfd_pkg::CMD_W_D;
    endcase
    job_ctl             = '0;
    job_ctl.status      = acfd_pkg::STAT_DISCARD;
    job_ctl.code        = acfd_pkg::CMD_STOP;
    job_ctl.zero        = 1'b1;
    job_ctl.allow_point = 1'b0;
    if (is_hash || at_full) begin
      if (head_eff == acfd_pkg::CH_B) begin
        job_ctl.status = acfd_pkg::STAT_OK;
        job_ctl.code   = acfd_pkg::CMD_WAVE;
        job_ctl.zero   = !is_hash || nul_eff;
      end else if (head_eff == acfd_pkg::CH_S) begin
        job_ctl.status = acfd_pkg::STAT_OK;
      end
    end else if ((head_eff == acfd_pkg::CH_W) || (head_eff == acfd_pkg::CH_V)) begin
      job_ctl.status      = acfd_pkg::STAT_OK;
      job_ctl.code        = tail_base + {2'b00, (head_eff == acfd_pkg::CH_V)};
      job_ctl.zero        = nul_eff;
      job_ctl.allow_point = 1'b1;
    end
    job_push = byte_acc && ends;
  end

  // Next frame state.
  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    nul_nxt  = nul_r;
    if (byte_acc) begin
      if (first) begin
        head_nxt = rx_byte;
      end
      if (ends) begin
        cnt_nxt = '0;
        nul_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt1;
        nul_nxt = nul_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      head_r <= '0;
      nul_r  <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
      nul_r  <= nul_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_acc) begin
      text_r <= text_nxt;
    end
  end

endmodule

// File: rtl/core/acfd_jobq.sv
module acfd_jobq #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] pop_data
);

  localparam int DEPTH = acfd_pkg::JOBQ_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  // Status and pointer updates.
  always_comb begin
    full    = (cnt_r == CNT_W'(DEPTH));
    valid   = (cnt_r != '0);
    do_push = push && !full;
    do_pop  = pop && valid;
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    pop_data = mem_r[rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/acfd_back.sv
module acfd_back #(
  parameter int NUMBER_CHARS = acfd_pkg::NUMBER_CHARS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 job_vld,
  input  acfd_pkg::job_ctl_t                   job_ctl,
  input  logic [$clog2(NUMBER_CHARS+1)-1:0]    job_len,
  input  logic [NUMBER_CHARS*8-1:0]            job_text,
  output logic                                 job_rd,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic                                 out_frame_status,
  output logic [2:0]                           out_command_code,
  output logic signed [acfd_pkg::VALUE_W-1:0]  out_command_value
);

  localparam int LEN_W = $clog2(NUMBER_CHARS + 1);
  localparam int H     = (NUMBER_CHARS + 1) / 2;
  localparam int NB    = NUMBER_CHARS - H;
  localparam int HA_W  = $clog2(10 ** H);
  localparam int HB_W  = $clog2(10 ** NB);
  localparam int CIB_W = $clog2(NB + 1);
  localparam int IP_W  = $clog2(10 ** NUMBER_CHARS);
  localparam int MAG_W = IP_W + acfd_pkg::FR_W;
  localparam int FR_W  = acfd_pkg::FR_W;
  localparam int VW    = acfd_pkg::VALUE_W;

  // Scan phases of the number text.
  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_INT  = 2'd1;
  localparam logic [1:0] PH_FRAC = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  typedef struct packed {
    logic       status;
    logic [2:0] code;
    logic       neg;
  } meta_t;

  function automatic logic [16:0] pow10(input logic [2:0] k);
    case (k)
      3'd0:    pow10 = 17'd1;
      3'd1:    pow10 = 17'd10;
      3'd2:    pow10 = 17'd100;
      3'd3:    pow10 = 17'd1000;
      3'd4:    pow10 = 17'd10000;
      3'd5:    pow10 = 17'd100000;
      default: pow10 = 17'd0;
    endcase
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == acfd_pkg::CH_SPACE) ||
               ((c >= acfd_pkg::CH_TAB) && (c <= acfd_pkg::CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= acfd_pkg::CH_ZERO) && (c <= acfd_pkg::CH_NINE);
  endfunction

  logic adv;

  // Stage valids.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_vld_r;
  meta_t meta1_r, meta2_r, meta3_r, meta4_r, meta5_r;

  // Stage 1: scan results.
  logic [NUMBER_CHARS-1:0] imask_c, fmask_c, imask1_r, fmask1_r;
  logic [3:0]              dig1_r [NUMBER_CHARS];
  logic                    neg_c;
  logic [1:0]              ph;
  logic [2:0]              fcnt;
  logic [7:0]              ch;
  logic                    live;

  // Stage 2: partial accumulations per half.
  logic [HA_W-1:0]  ia_c, ia2_r;
  logic [HB_W-1:0]  ib_c, ib2_r;
  logic [CIB_W-1:0] cib_c, cib2_r;
  logic [FR_W-1:0]  fa_c, fa2_r, fb_c, fb2_r;
  logic [2:0]       cfb_c, cfb2_r, nf_c, nf2_r;

  // Stage 3 to 5.
  logic [IP_W-1:0]  ip3_r;
  logic [FR_W-1:0]  fr3_r, frs4_r;
  logic [2:0]       nf3_r;
  logic [MAG_W-1:0] ips4_r, mag5_r;

  // Output stage.
  logic [63:0]   mag64;
  logic [63:0]   sat64;
  logic [VW-1:0] value_c;
  logic          out_status_r;
  logic [2:0]    out_code_r;
  logic [VW-1:0] out_value_r;

  // The whole pipe moves when the output register can take a transfer.
  always_comb begin
    adv       = !out_vld_r || out_pop;
    job_rd    = adv && job_vld;
    out_empty = !out_vld_r;
  end

  // Stage 1: mark integer and fraction digits in one walk over the text.
  always_comb begin
    ph      = PH_LEAD;
    neg_c   = 1'b0;
    imask_c = '0;
    fmask_c = '0;
    fcnt    = '0;
    ch      = '0;
    live    = 1'b0;
    for (int i = 0; i < NUMBER_CHARS; i++) begin
      ch   = job_text[i*8 +: 8];
      live = (LEN_W'(i) < job_len) && !job_ctl.zero;
      if (!live) begin
        ph = PH_DONE;
      end
      case (ph)
        PH_LEAD: begin
          if (is_space(ch)) begin
            ph = PH_LEAD;
          end else if ((ch == acfd_pkg::CH_PLUS) || (ch == acfd_pkg::CH_MINUS)) begin
            neg_c = (ch == acfd_pkg::CH_MINUS);
            ph    = PH_INT;
          end else if (is_digit(ch)) begin
            imask_c[i] = 1'b1;
            ph         = PH_INT;
          end else if (job_ctl.allow_point && (ch == acfd_pkg::CH_POINT)) begin
            ph = PH_FRAC;
          end else begin
            ph = PH_DONE;
          end
        end
        PH_INT: begin
          if (is_digit(ch)) begin
            imask_c[i] = 1'b1;
          end else if (job_ctl.allow_point && (ch == acfd_pkg::CH_POINT)) begin
            ph = PH_FRAC;
          end else begin
            ph = PH_DONE;
          end
        end
        PH_FRAC: begin
          if (is_digit(ch)) begin
            if (fcnt < acfd_pkg::FRAC_DIGITS) begin
              fmask_c[i] = 1'b1;
              fcnt       = fcnt + 3'd1;
            end
          end else begin
            ph = PH_DONE;
          end
        end
        default: begin
          ph = PH_DONE;
        end
      endcase
    end
  end

  // Stage 2: accumulate each half of the text separately.
  always_comb begin
    ia_c  = '0;
    ib_c  = '0;
    cib_c = '0;
    fa_c  = '0;
    fb_c  = '0;
    cfb_c = '0;
    nf_c  = '0;
    for (int i = 0; i < H; i++) begin
      if (imask1_r[i]) begin
        ia_c = ia_c * HA_W'(10) + HA_W'(dig1_r[i]);
      end
      if (fmask1_r[i]) begin
        fa_c = fa_c * FR_W'(10) + FR_W'(dig1_r[i]);
        nf_c = nf_c + 3'd1;
      end
    end
    for (int i = H; i < NUMBER_CHARS; i++) begin
      if (imask1_r[i]) begin
        ib_c  = ib_c * HB_W'(10) + HB_W'(dig1_r[i]);
        cib_c = cib_c + CIB_W'(1);
      end
      if (fmask1_r[i]) begin
        fb_c  = fb_c * FR_W'(10) + FR_W'(dig1_r[i]);
        cfb_c = cfb_c + 3'd1;
        nf_c  = nf_c + 3'd1;
      end
    end
  end

  // Saturate to the value range and apply the sign.
  always_comb begin
    mag64 = 64'(mag5_r);
    if (meta5_r.neg) begin
      sat64   = (mag64 > acfd_pkg::NEG_LIMIT) ? acfd_pkg::NEG_LIMIT : mag64;
      value_c = VW'(0) - VW'(sat64);
    end else begin
      sat64   = (mag64 > acfd_pkg::POS_LIMIT) ? acfd_pkg::POS_LIMIT : mag64;
      value_c = VW'(sat64);
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      v1_r      <= job_vld;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      out_vld_r <= v5_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      meta1_r.status <= job_ctl.status;
      meta1_r.code   <= job_ctl.code;
      meta1_r.neg    <= neg_c;
      imask1_r       <= imask_c;
      fmask1_r       <= fmask_c;
      for (int i = 0; i < NUMBER_CHARS; i++) begin
        dig1_r[i] <= job_text[i*8 +: 4];
      end

      meta2_r <= meta1_r;
      ia2_r   <= ia_c;
      ib2_r   <= ib_c;
      cib2_r  <= cib_c;
      fa2_r   <= fa_c;
      fb2_r   <= fb_c;
      cfb2_r  <= cfb_c;
      nf2_r   <= nf_c;

      meta3_r <= meta2_r;
      ip3_r   <= IP_W'(ia2_r) * IP_W'(pow10(3'(cib2_r))) + IP_W'(ib2_r);
      fr3_r   <= fa2_r * pow10(cfb2_r) + fb2_r;
      nf3_r   <= nf2_r;

      meta4_r <= meta3_r;
      ips4_r  <= MAG_W'(ip3_r) * MAG_W'(acfd_pkg::SCALE);
      frs4_r  <= fr3_r * pow10(acfd_pkg::FRAC_DIGITS - nf3_r);

      meta5_r <= meta4_r;
      mag5_r  <= ips4_r + MAG_W'(frs4_r);

      out_status_r <= meta5_r.status;
      out_code_r   <= meta5_r.code;
      out_value_r  <= value_c;
    end
  end

  assign out_frame_status  = out_status_r;
  assign out_command_code  = out_code_r;
  assign out_command_value = out_value_r;

endmodule

// File: rtl/core/ascii_command_frame_decoder.sv
// A frame's result passes from the edge that takes its ending byte through the job queue,
// the value pipeline stages and the output register before it reaches the result ports.
// Throughput: one byte per cycle while in_full is low; one result per cycle while pop is held
// high. The job queue holds 4 ended frames; full rises only once the result side has stalled.
// Reset: synchronous, active low; clears the frame position, head byte, queue and pipeline.
module ascii_command_frame_decoder #(
  parameter int BUFFER_LEN   = acfd_pkg::BUFFER_LEN_DEF,
  parameter int NUMBER_CHARS = acfd_pkg::NUMBER_CHARS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [7:0]                          in_rx_byte,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic                                out_frame_status,
  output logic [2:0]                          out_command_code,
  output logic signed [acfd_pkg::VALUE_W-1:0] out_command_value
);

  localparam int LEN_W = $clog2(NUMBER_CHARS + 1);
  localparam int CTL_W = $bits(acfd_pkg::job_ctl_t);
  localparam int JOB_W = CTL_W + LEN_W + NUMBER_CHARS * 8;

  logic                      in_acc;
  logic                      job_push;
  acfd_pkg::job_ctl_t        job_ctl;
  logic [LEN_W-1:0]          job_len;
  logic [NUMBER_CHARS*8-1:0] job_text;
  logic                      q_full;
  logic                      q_valid;
  logic                      q_pop;
  logic [JOB_W-1:0]          q_in;
  logic [JOB_W-1:0]          q_out;
  acfd_pkg::job_ctl_t        q_ctl;
  logic [LEN_W-1:0]          q_len;
  logic [NUMBER_CHARS*8-1:0] q_text;

  // An input transfer needs room in the job queue.
  assign in_full = q_full;
  assign in_acc  = in_push && !q_full;

  acfd_front #(
    .BUFFER_LEN   (BUFFER_LEN),
    .NUMBER_CHARS (NUMBER_CHARS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_acc (in_acc),
    .rx_byte  (in_rx_byte),
    .job_push (job_push),
    .job_ctl  (job_ctl),
    .job_len  (job_len),
    .job_text (job_text)
  );

  // Pack and unpack jobs around the queue.
  assign q_in                    = {job_ctl, job_len, job_text};
  assign {q_ctl, q_len, q_text}  = q_out;

  acfd_jobq #(
    .W (JOB_W)
  ) u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  acfd_back #(
    .NUMBER_CHARS (NUMBER_CHARS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_vld           (q_valid),
    .job_ctl           (q_ctl),
    .job_len           (q_len),
    .job_text          (q_text),
    .job_rd            (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_frame_status  (out_frame_status),
    .out_command_code  (out_command_code),
    .out_command_value (out_command_value)
  );

  // A job only leaves the front for a byte that was actually transferred.
  assert property (@(posedge clk) disable iff (!rst_n) job_push |-> (in_acc && !q_full))
    else $error("job pushed without an accepted byte");

  // A transferred '#' always ends the frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_rx_byte == acfd_pkg::CH_HASH)) |-> job_push)
    else $error("hash byte did not end the frame");

  // A held result freezes the pipeline, so no job is drawn from the queue.
  assert property (@(posedge clk) disable iff (!rst_n) (!out_empty && !out_pop) |-> !q_pop)
    else $error("job drawn while the output is stalled");

  // Reset leaves both the queue and the output empty.
  assert property (@(posedge clk) !$past(rst_n) |-> (out_empty && !q_valid))
    else $error("results present right after reset");

endmodule
